/* hdl/kvbrd_pkg.sv */
// ---------------------------------------------------------------------------
// kvbrd_pkg: shared types and constants of the request deframer
// Header layout, command kinds, status codes, body regions and the opcode map.
// ---------------------------------------------------------------------------
package kvbrd_pkg;

  localparam int unsigned HdrBytes = 24;
  localparam int unsigned IdxW     = 5;

  localparam logic [IdxW-1:0] LastIdx      = IdxW'(HdrBytes - 1);
  localparam logic [7:0]      RequestMagic = 8'h80;
  localparam logic [7:0]      StorageExtras = 8'd8;
  localparam logic [7:0]      DeltaExtras   = 8'd20;
  localparam logic [7:0]      FlushExtras   = 8'd4;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_DELETE  = 3'd1,
    KIND_STORAGE = 3'd2,
    KIND_CONCAT  = 3'd3,
    KIND_DELTA   = 3'd4,
    KIND_FLUSH   = 3'd5,
    KIND_OTHER   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_BAD_MAGIC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REGION_EXTRAS = 2'd0,
    REGION_KEY    = 2'd1,
    REGION_VALUE  = 2'd2
  } region_e;

  typedef enum logic {
    REC_DESC = 1'b0,
    REC_BODY = 1'b1
  } rec_kind_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  // Header fields as collected from the byte stream.
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  extras_len;
    logic [15:0] key_len;
    logic [31:0] body_size;
    logic [31:0] opaque;
    logic [63:0] cas;
  } hdr_t;

  // Classification of a complete header.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic        forward;
    logic [16:0] key_end;
  } class_t;

  typedef struct packed {
    logic  known;
    kind_e kind;
  } opmap_t;

  // One output record as held in the result register.
  typedef struct packed {
    rec_kind_e   rec_type;
    logic [7:0]  opcode;
    kind_e       kind;
    status_e     status;
    logic [7:0]  extras_len;
    logic [15:0] key_len;
    logic [31:0] body_size;
    logic [31:0] opaque;
    logic [63:0] cas;
    logic [7:0]  body_byte;
    region_e     region;
    logic        last;
  } rec_t;

  function automatic opmap_t map_opcode(input logic [7:0] op);
    opmap_t m;
    m.known = 1'b1;
    case (op) inside
      8'h00, 8'h09, 8'h0c, 8'h0d:               m.kind = KIND_LOOKUP;
      8'h04, 8'h14:                             m.kind = KIND_DELETE;
      8'h01, 8'h02, 8'h03, 8'h11, 8'h12, 8'h13: m.kind = KIND_STORAGE;
      8'h0e, 8'h0f, 8'h19, 8'h1a:               m.kind = KIND_CONCAT;
      8'h05, 8'h06, 8'h15, 8'h16:               m.kind = KIND_DELTA;
      8'h08, 8'h18:                             m.kind = KIND_FLUSH;
      8'h07, 8'h0a, 8'h0b, 8'h10, 8'h17:        m.kind = KIND_OTHER;
      default: begin
        m.known = 1'b0;
        m.kind  = KIND_OTHER;
      end
    endcase
    return m;
  endfunction

endpackage

/* hdl/kvbrd_in_if.sv */
// ---------------------------------------------------------------------------
// kvbrd_in_if: request byte channel
// Valid/ready channel that carries one byte of the request stream.
// ---------------------------------------------------------------------------
interface kvbrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

/* hdl/kvbrd_out_if.sv */
// ---------------------------------------------------------------------------
// kvbrd_out_if: record channel
// Valid/ready channel that carries command descriptors and body bytes.
// ---------------------------------------------------------------------------
interface kvbrd_out_if;
  logic        valid;
  logic        ready;
  logic        record_type;
  logic [7:0]  command_opcode;
  logic [2:0]  command_kind;
  logic [1:0]  status;
  logic [7:0]  extras_length;
  logic [15:0] key_length;
  logic [31:0] body_length;
  logic [31:0] opaque_word;
  logic [63:0] cas_stamp;
  logic [7:0]  body_byte;
  logic [1:0]  body_region;
  logic        last;

  modport source (
    output valid, input ready,
    output record_type, command_opcode, command_kind, status, extras_length,
    output key_length, body_length, opaque_word, cas_stamp, body_byte,
    output body_region, last
  );
  modport sink (
    input valid, output ready,
    input record_type, command_opcode, command_kind, status, extras_length,
    input key_length, body_length, opaque_word, cas_stamp, body_byte,
    input body_region, last
  );
endinterface

/* hdl/kvbrd_hdr_collect.sv */
// ---------------------------------------------------------------------------
// kvbrd_hdr_collect: header field registers
// Shifts header bytes into their big-endian fields by position.
// ---------------------------------------------------------------------------
module kvbrd_hdr_collect
  import kvbrd_pkg::*;
(
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [7:0]      byte_i,
  output hdr_t            hdr_o
);

  hdr_t hdr_q;

  // Magic, data type and reserved bytes are not kept.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (idx_i) inside
        5'd1:        hdr_q.opcode     <= byte_i;
        [5'd2:5'd3]:   hdr_q.key_len  <= {hdr_q.key_len[7:0], byte_i};
        5'd4:        hdr_q.extras_len <= byte_i;
        [5'd8:5'd11]:  hdr_q.body_size <= {hdr_q.body_size[23:0], byte_i};
        [5'd12:5'd15]: hdr_q.opaque   <= {hdr_q.opaque[23:0], byte_i};
        [5'd16:5'd23]: hdr_q.cas      <= {hdr_q.cas[55:0], byte_i};
        default: ;
      endcase
    end
  end

  assign hdr_o = hdr_q;

endmodule

/* hdl/kvbrd_classify.sv */
// ---------------------------------------------------------------------------
// kvbrd_classify: command classification
// Maps the opcode to a kind and checks the length rules of that kind.
// ---------------------------------------------------------------------------
module kvbrd_classify
  import kvbrd_pkg::*;
(
  input  hdr_t   hdr_i,
  output class_t cls_o
);

  opmap_t      opm;
  logic [16:0] key_end;
  logic        too_long;
  logic        key_nz;
  logic        key_eq_body;
  logic        end_eq_body;
  logic        args_ok;
  status_e     status;
  kind_e       kind;

  always_comb begin
    opm         = map_opcode(hdr_i.opcode);
    key_end     = {1'b0, hdr_i.key_len} + {9'b0, hdr_i.extras_len};
    too_long    = {15'b0, key_end} > hdr_i.body_size;
    key_nz      = hdr_i.key_len != 16'd0;
    key_eq_body = {16'b0, hdr_i.key_len} == hdr_i.body_size;
    end_eq_body = {15'b0, key_end} == hdr_i.body_size;

    case (opm.kind)
      KIND_LOOKUP, KIND_DELETE:
        args_ok = (hdr_i.extras_len == 8'd0) && key_eq_body && key_nz;
      KIND_STORAGE:
        args_ok = (hdr_i.extras_len == StorageExtras) && key_nz;
      KIND_CONCAT:
        args_ok = (hdr_i.extras_len == 8'd0) && !key_eq_body && key_nz;
      KIND_DELTA:
        args_ok = (hdr_i.extras_len == DeltaExtras) && end_eq_body && key_nz;
      KIND_FLUSH:
        args_ok = ((hdr_i.extras_len == 8'd0) || (hdr_i.extras_len == FlushExtras))
                  && !key_nz && (hdr_i.body_size == {24'b0, hdr_i.extras_len});
      default:
        args_ok = 1'b1;
    endcase

    // The length check takes precedence over the opcode check.
    if (too_long) begin
      status = ST_INVALID;
    end else if (!opm.known) begin
      status = ST_UNKNOWN;
    end else if (!args_ok) begin
      status = ST_INVALID;
    end else begin
      status = ST_OK;
    end
    kind = opm.kind;

    cls_o.kind    = kind;
    cls_o.status  = status;
    cls_o.forward = (status == ST_OK) && (kind != KIND_OTHER);
    cls_o.key_end = key_end;
  end

endmodule

/* hdl/kv_binary_request_deframer.sv */
// ---------------------------------------------------------------------------
// kv_binary_request_deframer: binary key-value request deframer
// Splits a request byte stream into command descriptors and tagged body bytes.
// ---------------------------------------------------------------------------
// Usage:
// The request stream enters on req_i, one byte per transaction. Results leave
// on rec_o, at most one record per input byte: a command descriptor when the
// 24th header byte arrives (or at once on a bad first byte), and one record
// per body byte of a forwarded command, tagged extras, key or value.
// A byte taken from req_i sits in the input register while it is decoded,
// and its record is written to the result register that drives rec_o.
// Throughput is one byte per cycle while the receiver keeps up; the header and
// body counters and the length checks are all worked out in the decode step.
// When the receiver stalls, the input register still takes one more byte, and
// bytes that produce no record keep draining while the record waits.
// Reset clears the phase, the header position and the body counters; the
// block then expects the magic byte of a new request. After a bad magic byte
// the block swallows every byte until the next reset.
// ---------------------------------------------------------------------------
module kv_binary_request_deframer
  import kvbrd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  kvbrd_in_if.sink     req_i,
  kvbrd_out_if.source  rec_o
);

  // Input register stage.
  logic [7:0] byte_q;
  logic       bvalid_q;

  // Parser state.
  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q;
  logic [31:0]     remaining_q;
  logic [31:0]     offset_q;
  logic            fwd_q;

  // Result register.
  rec_t rec_q, rec_d;
  logic ovalid_q;

  hdr_t   hdr;
  class_t cls;

  logic produce;
  logic hdr_wr;
  logic consume;
  logic out_free;
  logic bad_magic;
  logic hdr_done;
  logic body_end;

  assign out_free  = !ovalid_q || rec_o.ready;
  // A byte can always retire if it yields no record; otherwise it needs room.
  assign consume   = bvalid_q && (out_free || !produce);
  assign req_i.ready = !bvalid_q || consume;

  assign bad_magic = (idx_q == '0) && (byte_q != RequestMagic);
  assign hdr_done  = idx_q == LastIdx;
  assign body_end  = remaining_q[31:1] == 31'd0;

  kvbrd_hdr_collect u_hdr (
    .clk_i   (clk_i),
    .wr_en_i (consume && hdr_wr),
    .idx_i   (idx_q),
    .byte_i  (byte_q),
    .hdr_o   (hdr)
  );

  kvbrd_classify u_cls (
    .hdr_i (hdr),
    .cls_o (cls)
  );

  // Record generation for the byte in the input register.
  always_comb begin
    rec_d   = '0;
    produce = 1'b0;
    hdr_wr  = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        if (bad_magic) begin
          produce      = 1'b1;
          rec_d.status = ST_BAD_MAGIC;
          rec_d.last   = 1'b1;
        end else begin
          hdr_wr = 1'b1;
          if (hdr_done) begin
            // The last CAS byte is still in flight, so it is merged here.
            produce          = 1'b1;
            rec_d.rec_type   = REC_DESC;
            rec_d.opcode     = hdr.opcode;
            rec_d.kind       = cls.kind;
            rec_d.status     = cls.status;
            rec_d.extras_len = hdr.extras_len;
            rec_d.key_len    = hdr.key_len;
            rec_d.body_size  = hdr.body_size;
            rec_d.opaque     = hdr.opaque;
            rec_d.cas        = {hdr.cas[55:0], byte_q};
            rec_d.last       = !(cls.forward && (hdr.body_size != 32'd0));
          end
        end
      end
      PH_BODY: begin
        if (fwd_q) begin
          produce         = 1'b1;
          rec_d.rec_type  = REC_BODY;
          rec_d.body_byte = byte_q;
          rec_d.last      = body_end;
          if (offset_q < {24'b0, hdr.extras_len}) begin
            rec_d.region = REGION_EXTRAS;
          end else if (offset_q < {15'b0, cls.key_end}) begin
            rec_d.region = REGION_KEY;
          end else begin
            rec_d.region = REGION_VALUE;
          end
        end
      end
      default: ;
    endcase
  end

  // Phase transitions.
  always_comb begin
    phase_d = phase_q;
    if (consume) begin
      case (phase_q)
        PH_HEADER: begin
          if (bad_magic) begin
            phase_d = PH_DISCARD;
          end else if (hdr_done && (hdr.body_size != 32'd0)) begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_end) begin
            phase_d = PH_HEADER;
          end
        end
        default: phase_d = PH_DISCARD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
    end else if (req_i.ready) begin
      bvalid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      byte_q <= req_i.stream_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      idx_q       <= '0;
      remaining_q <= '0;
      offset_q    <= '0;
      fwd_q       <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (consume) begin
        case (phase_q)
          PH_HEADER: begin
            if (!bad_magic) begin
              if (hdr_done) begin
                idx_q       <= '0;
                remaining_q <= hdr.body_size;
                offset_q    <= '0;
                fwd_q       <= cls.forward;
              end else begin
                idx_q <= idx_q + IdxW'(1);
              end
            end
          end
          PH_BODY: begin
            remaining_q <= remaining_q - 32'd1;
            if (body_end) begin
              offset_q <= '0;
              fwd_q    <= 1'b0;
            end else begin
              offset_q <= offset_q + 32'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_free) begin
      ovalid_q <= consume && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && produce) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o.valid          = ovalid_q;
  assign rec_o.record_type    = rec_q.rec_type;
  assign rec_o.command_opcode = rec_q.opcode;
  assign rec_o.command_kind   = rec_q.kind;
  assign rec_o.status         = rec_q.status;
  assign rec_o.extras_length  = rec_q.extras_len;
  assign rec_o.key_length     = rec_q.key_len;
  assign rec_o.body_length    = rec_q.body_size;
  assign rec_o.opaque_word    = rec_q.opaque;
  assign rec_o.cas_stamp      = rec_q.cas;
  assign rec_o.body_byte      = rec_q.body_byte;
  assign rec_o.body_region    = rec_q.region;
  assign rec_o.last           = rec_q.last;

endmodule

/* sim/kvbrd_tb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvbrd_tb_pkg: opcode names for the deframer testbench
// Request opcodes of the binary key-value protocol, shared by stimulus and checker.
// ---------------------------------------------------------------------------
package kvbrd_tb_pkg;

  typedef enum logic [7:0] {
    OP_GET        = 8'h00,
    OP_SET        = 8'h01,
    OP_ADD        = 8'h02,
    OP_REPLACE    = 8'h03,
    OP_DELETE     = 8'h04,
    OP_INCREMENT  = 8'h05,
    OP_DECREMENT  = 8'h06,
    OP_QUIT       = 8'h07,
    OP_FLUSH      = 8'h08,
    OP_GETQ       = 8'h09,
    OP_NOOP       = 8'h0a,
    OP_VERSION    = 8'h0b,
    OP_GETK       = 8'h0c,
    OP_GETKQ      = 8'h0d,
    OP_APPEND     = 8'h0e,
    OP_PREPEND    = 8'h0f,
    OP_STAT       = 8'h10,
    OP_SETQ       = 8'h11,
    OP_ADDQ       = 8'h12,
    OP_REPLACEQ   = 8'h13,
    OP_DELETEQ    = 8'h14,
    OP_INCREMENTQ = 8'h15,
    OP_DECREMENTQ = 8'h16,
    OP_QUITQ      = 8'h17,
    OP_FLUSHQ     = 8'h18,
    OP_APPENDQ    = 8'h19,
    OP_PREPENDQ   = 8'h1a
  } opcode_e;

  // First opcode value past the defined set, and the top of the opcode range.
  localparam logic [7:0] OpcodeCount = 8'h1b;
  localparam logic [7:0] OpcodeMax   = 8'hff;

endpackage

/* sim/kvbrd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvbrd_checker: scoreboard for the request deframer
// Watches both channels, predicts the records of every accepted byte and
// compares each accepted record field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module kvbrd_checker
  import kvbrd_pkg::*;
  import kvbrd_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  kvbrd_in_if         req_i,
  kvbrd_out_if        rec_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned desc_count_o,
  output int unsigned body_count_o
);

  // Shadow state of the deframer.
  phase_e      phase_q;
  logic [4:0]  hdr_fill;
  logic [7:0]  hdr_seen [HdrBytes];
  logic [31:0] body_left;
  logic [31:0] body_pos;
  logic        body_fwd;
  rec_t        due_records [$];

  function automatic opmap_t kind_of_opcode(input logic [7:0] op);
    opmap_t m;
    m.known = 1'b1;
    case (op)
      OP_GET, OP_GETQ, OP_GETK, OP_GETKQ:                  m.kind = KIND_LOOKUP;
      OP_DELETE, OP_DELETEQ:                               m.kind = KIND_DELETE;
      OP_SET, OP_ADD, OP_REPLACE, OP_SETQ, OP_ADDQ, OP_REPLACEQ:
        m.kind = KIND_STORAGE;
      OP_APPEND, OP_PREPEND, OP_APPENDQ, OP_PREPENDQ:      m.kind = KIND_CONCAT;
      OP_INCREMENT, OP_DECREMENT, OP_INCREMENTQ, OP_DECREMENTQ:
        m.kind = KIND_DELTA;
      OP_FLUSH, OP_FLUSHQ:                                 m.kind = KIND_FLUSH;
      OP_QUIT, OP_NOOP, OP_VERSION, OP_STAT, OP_QUITQ:     m.kind = KIND_OTHER;
      default: begin
        m.known = 1'b0;
        m.kind  = KIND_OTHER;
      end
    endcase
    return m;
  endfunction

  // Per-kind rules on extras, key and body lengths.
  function automatic logic args_fit(input kind_e k, input logic [7:0] ext,
                                    input logic [15:0] key, input logic [31:0] body);
    case (k)
      KIND_LOOKUP, KIND_DELETE: return ext == 8'd0 && 32'(key) == body && key != 16'd0;
      KIND_STORAGE:             return ext == StorageExtras && key != 16'd0;
      KIND_CONCAT:              return ext == 8'd0 && 32'(key) != body && key != 16'd0;
      KIND_DELTA:
        return ext == DeltaExtras && 32'(key) + 32'(ext) == body && key != 16'd0;
      KIND_FLUSH:
        return (ext == 8'd0 || ext == FlushExtras) && key == 16'd0 && body == 32'(ext);
      default:                  return 1'b1;
    endcase
  endfunction

  function automatic string rec_text(input rec_t r);
    return $sformatf({"type=%0d op=%02h kind=%0d st=%0d ext=%0d key=%0d body=%0d ",
                      "opq=%08h cas=%016h byte=%02h reg=%0d last=%0d"},
                     r.rec_type, r.opcode, r.kind, r.status, r.extras_len, r.key_len,
                     r.body_size, r.opaque, r.cas, r.body_byte, r.region, r.last);
  endfunction

  task automatic close_header();
    rec_t        r;
    opmap_t      m;
    logic [7:0]  ext;
    logic [15:0] key;
    logic [31:0] body;
    ext  = hdr_seen[4];
    key  = {hdr_seen[2], hdr_seen[3]};
    body = {hdr_seen[8], hdr_seen[9], hdr_seen[10], hdr_seen[11]};
    m    = kind_of_opcode(hdr_seen[1]);
    r            = '0;
    r.rec_type   = REC_DESC;
    r.opcode     = hdr_seen[1];
    r.kind       = m.kind;
    // The length sum is checked ahead of the opcode.
    if (33'(key) + 33'(ext) > 33'(body)) r.status = ST_INVALID;
    else if (!m.known) r.status = ST_UNKNOWN;
    else if (!args_fit(m.kind, ext, key, body)) r.status = ST_INVALID;
    else r.status = ST_OK;
    r.extras_len = ext;
    r.key_len    = key;
    r.body_size  = body;
    r.opaque     = {hdr_seen[12], hdr_seen[13], hdr_seen[14], hdr_seen[15]};
    r.cas        = {hdr_seen[16], hdr_seen[17], hdr_seen[18], hdr_seen[19],
                    hdr_seen[20], hdr_seen[21], hdr_seen[22], hdr_seen[23]};
    body_fwd  = (r.status == ST_OK) && (m.kind != KIND_OTHER);
    body_left = body;
    body_pos  = '0;
    hdr_fill  = '0;
    phase_q   = (body != 32'd0) ? PH_BODY : PH_HEADER;
    r.last    = !(body_fwd && body != 32'd0);
    due_records.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    rec_t        r;
    logic [31:0] ext_end;
    logic [31:0] key_end;
    case (phase_q)
      PH_HEADER: begin
        if (hdr_fill == '0 && b != RequestMagic) begin
          r        = '0;
          r.status = ST_BAD_MAGIC;
          r.last   = 1'b1;
          due_records.push_back(r);
          phase_q  = PH_DISCARD;
        end else begin
          hdr_seen[hdr_fill] = b;
          hdr_fill++;
          if (hdr_fill == HdrBytes) close_header();
        end
      end
      PH_BODY: begin
        ext_end = 32'(hdr_seen[4]);
        key_end = ext_end + 32'({hdr_seen[2], hdr_seen[3]});
        if (body_fwd) begin
          r           = '0;
          r.rec_type  = REC_BODY;
          r.body_byte = b;
          if (body_pos < ext_end) r.region = REGION_EXTRAS;
          else if (body_pos < key_end) r.region = REGION_KEY;
          else r.region = REGION_VALUE;
          r.last = (body_left <= 32'd1);
          due_records.push_back(r);
        end
        body_pos++;
        if (body_left != 32'd0) body_left--;
        if (body_left == 32'd0) begin
          phase_q  = PH_HEADER;
          hdr_fill = '0;
          body_pos = '0;
          body_fwd = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_record();
    rec_t got;
    rec_t want;
    got.rec_type   = rec_kind_e'(rec_i.record_type);
    got.opcode     = rec_i.command_opcode;
    got.kind       = kind_e'(rec_i.command_kind);
    got.status     = status_e'(rec_i.status);
    got.extras_len = rec_i.extras_length;
    got.key_len    = rec_i.key_length;
    got.body_size  = rec_i.body_length;
    got.opaque     = rec_i.opaque_word;
    got.cas        = rec_i.cas_stamp;
    got.body_byte  = rec_i.body_byte;
    got.region     = region_e'(rec_i.body_region);
    got.last       = rec_i.last;
    if (due_records.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("[%0t] record with none pending: %s", $time, rec_text(got));
      end
    end else begin
      want = due_records.pop_front();
      if (got.rec_type !== want.rec_type || got.opcode !== want.opcode ||
          got.kind !== want.kind || got.status !== want.status ||
          got.extras_len !== want.extras_len || got.key_len !== want.key_len ||
          got.body_size !== want.body_size || got.opaque !== want.opaque ||
          got.cas !== want.cas || got.body_byte !== want.body_byte ||
          got.region !== want.region || got.last !== want.last) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("[%0t] record mismatch", $time);
          $display("  expected %s", rec_text(want));
          $display("  actual   %s", rec_text(got));
        end
      end else if (want.rec_type == REC_DESC) begin
        desc_count_o++;
      end else begin
        body_count_o++;
      end
    end
  endtask

  // Records are compared before the byte of the same edge is predicted; a byte's
  // record passes the input and result registers first, so the order makes no difference.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   = PH_HEADER;
      hdr_fill  = '0;
      body_left = '0;
      body_pos  = '0;
      body_fwd  = 1'b0;
      foreach (hdr_seen[i]) hdr_seen[i] = '0;
      due_records.delete();
      fail_count_o = 0;
      desc_count_o = 0;
      body_count_o = 0;
    end else begin
      if (rec_i.valid && rec_i.ready) check_record();
      if (req_i.valid && req_i.ready) deframe_byte(req_i.stream_byte);
    end
    pending_o = due_records.size();
  end

endmodule

/* sim/kv_binary_request_deframer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kv_binary_request_deframer_tb: testbench of the request deframer
// Sends directed and random binary requests with random handshake gaps and
// long receiver hold-offs, and ends with a bad magic byte that locks the block.
// ---------------------------------------------------------------------------
module kv_binary_request_deframer_tb;
  import kvbrd_pkg::*;
  import kvbrd_tb_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 11;
  // The directed requests and the closing lockout add about 650 bytes.
  localparam int unsigned RandomBytes = 1000;
  // The limit lies well above the length of the slowest correct run.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 400;
  // The drain also covers one full receiver gap.
  localparam int unsigned DrainCycles = 40;

  logic clk_i;
  logic rst_ni;

  kvbrd_in_if  req_if ();
  kvbrd_out_if rec_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned desc_count;
  int unsigned body_count;
  int unsigned bytes_sent    = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  int unsigned in_calm       = 0;
  int unsigned out_calm      = 0;
  logic        hold_req      = 1'b0;

  kv_binary_request_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rec_o  (rec_if)
  );

  // The checker sees both channels and reports how many records are still due.
  kvbrd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rec_i        (rec_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .desc_count_o (desc_count),
    .body_count_o (body_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // A hung handshake is caught here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d records outstanding.", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Each side draws a random wait before each transaction. Now and then it
  // enters a calm stretch of back-to-back transactions with no wait at all.
  task automatic draw_gap(inout int unsigned calm, output int unsigned gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(12, 40);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, 17);
    end
  endtask

  // Receiver side. The hold-off request turns into one long wait, counted here,
  // while the sender keeps offering bytes so that the block backs up.
  initial begin : record_sink
    int unsigned gap;
    rec_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        gap      = HoldCycles;
        hold_req = 1'b0;
      end else begin
        draw_gap(out_calm, gap);
      end
      if (gap > 0) begin
        rec_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rec_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rec_if.valid && rec_if.ready));
    end
  end

  // Offers one byte and returns at the falling edge after the transaction.
  // Valid stays high across back-to-back bytes, so it is never lowered and
  // raised in the same time step.
  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    draw_gap(in_calm, gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.stream_byte <= b;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Builds the 24-byte big-endian header and follows it with body_size random
  // body bytes. The data type and reserved bytes are random filler.
  task automatic send_request(input logic [7:0] op, input logic [7:0] ext,
                              input logic [15:0] key, input logic [31:0] body_size,
                              input logic [31:0] opaque, input logic [63:0] cas);
    logic [7:0] hdr [HdrBytes];
    hdr[0] = RequestMagic;
    hdr[1] = op;
    hdr[2] = key[15:8];
    hdr[3] = key[7:0];
    hdr[4] = ext;
    hdr[5] = 8'($urandom);
    hdr[6] = 8'($urandom);
    hdr[7] = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      hdr[8 + i]  = body_size[31 - 8 * i -: 8];
      hdr[12 + i] = opaque[31 - 8 * i -: 8];
    end
    for (int i = 0; i < 8; i++) hdr[16 + i] = cas[63 - 8 * i -: 8];
    for (int i = 0; i < HdrBytes; i++) put_byte(hdr[i]);
    for (int unsigned i = 0; i < body_size; i++) put_byte(8'($urandom));
    requests_sent++;
  endtask

  function automatic logic [7:0] opcode_for(input kind_e k);
    case (k)
      KIND_LOOKUP:
        case ($urandom_range(0, 3))
          0:       return OP_GET;
          1:       return OP_GETQ;
          2:       return OP_GETK;
          default: return OP_GETKQ;
        endcase
      KIND_DELETE:
        return $urandom_range(0, 1) ? OP_DELETE : OP_DELETEQ;
      KIND_STORAGE:
        case ($urandom_range(0, 5))
          0:       return OP_SET;
          1:       return OP_ADD;
          2:       return OP_REPLACE;
          3:       return OP_SETQ;
          4:       return OP_ADDQ;
          default: return OP_REPLACEQ;
        endcase
      KIND_CONCAT:
        case ($urandom_range(0, 3))
          0:       return OP_APPEND;
          1:       return OP_PREPEND;
          2:       return OP_APPENDQ;
          default: return OP_PREPENDQ;
        endcase
      KIND_DELTA:
        case ($urandom_range(0, 3))
          0:       return OP_INCREMENT;
          1:       return OP_DECREMENT;
          2:       return OP_INCREMENTQ;
          default: return OP_DECREMENTQ;
        endcase
      KIND_FLUSH:
        return $urandom_range(0, 1) ? OP_FLUSH : OP_FLUSHQ;
      default:
        case ($urandom_range(0, 4))
          0:       return OP_QUIT;
          1:       return OP_NOOP;
          2:       return OP_VERSION;
          3:       return OP_STAT;
          default: return OP_QUITQ;
        endcase
    endcase
  endfunction

  // Most random requests obey the rules of their kind, so that bodies get
  // forwarded; about two in five are bent afterwards to hit the error paths.
  // Bodies stay short, with an occasional long value to fill the pipeline.
  task automatic send_random_request();
    kind_e       k;
    logic [7:0]  op;
    logic [7:0]  ext;
    logic [15:0] key;
    logic [31:0] body;
    int unsigned vlen;
    k    = kind_e'($urandom_range(0, 6));
    op   = opcode_for(k);
    key  = 16'($urandom_range(1, 6));
    vlen = ($urandom_range(0, 15) == 0) ? $urandom_range(24, 64) : $urandom_range(0, 8);
    case (k)
      KIND_LOOKUP, KIND_DELETE: begin
        ext  = 8'd0;
        body = 32'(key);
      end
      KIND_STORAGE: begin
        ext  = StorageExtras;
        body = 32'(ext) + 32'(key) + vlen;
      end
      KIND_CONCAT: begin
        ext  = 8'd0;
        body = 32'(key) + vlen + 1;
      end
      KIND_DELTA: begin
        ext  = DeltaExtras;
        body = 32'(ext) + 32'(key);
      end
      KIND_FLUSH: begin
        ext  = $urandom_range(0, 1) ? FlushExtras : 8'd0;
        key  = 16'd0;
        body = 32'(ext);
      end
      default: begin
        ext  = 8'($urandom_range(0, 4));
        key  = 16'($urandom_range(0, 4));
        body = 32'(ext) + 32'(key) + vlen;
      end
    endcase
    case ($urandom_range(0, 14))
      0: ext = ext ^ 8'(1 << $urandom_range(0, 7));
      1: key = key + 16'd1;
      2: key = key - 16'd1;
      3: begin
        if (body != 32'd0 && $urandom_range(0, 1)) body = body - 32'd1;
        else body = body + 32'd1;
      end
      4: op = 8'($urandom_range(OpcodeCount, OpcodeMax));
      5: key = 16'($urandom);
      default: ;
    endcase
    send_request(op, ext, key, body, $urandom, {$urandom, $urandom});
  endtask

  initial begin : stimulus
    int unsigned random_start;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.stream_byte = 8'd0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests: every kind with good lengths, most with bad ones, field extremes.
    send_request(OP_GET, 8'd0, 16'd3, 32'd3, '1, '1);
    send_request(OP_GETK, 8'd0, 16'd1, 32'd1, '0, '0);
    send_request(OP_DELETE, 8'd0, 16'd2, 32'd2, $urandom, {$urandom, $urandom});
    // Storage with extras, key and value regions in the body.
    send_request(OP_SET, StorageExtras, 16'd3, 32'd15, $urandom, {$urandom, $urandom});
    send_request(OP_ADDQ, StorageExtras, 16'd0, 32'd8, $urandom, {$urandom, $urandom});
    send_request(OP_APPEND, 8'd0, 16'd2, 32'd5, $urandom, {$urandom, $urandom});
    // A concat whose key fills the whole body is rejected.
    send_request(OP_PREPENDQ, 8'd0, 16'd3, 32'd3, $urandom, {$urandom, $urandom});
    send_request(OP_INCREMENT, DeltaExtras, 16'd2, 32'd22, $urandom, {$urandom, $urandom});
    send_request(OP_DECREMENTQ, DeltaExtras, 16'd2, 32'd23, $urandom, {$urandom, $urandom});
    // Flush without a body gives a lone descriptor; with extras that match the body they are forwarded.
    send_request(OP_FLUSH, 8'd0, 16'd0, 32'd0, $urandom, {$urandom, $urandom});
    send_request(OP_FLUSHQ, FlushExtras, 16'd0, 32'd4, $urandom, {$urandom, $urandom});
    send_request(OP_FLUSH, FlushExtras, 16'd0, 32'd5, $urandom, {$urandom, $urandom});
    // Other-kind commands are accepted but their bodies vanish.
    send_request(OP_NOOP, 8'd0, 16'd0, 32'd0, $urandom, {$urandom, $urandom});
    send_request(OP_STAT, 8'd2, 16'd3, 32'd9, $urandom, {$urandom, $urandom});
    send_request(OP_QUIT, 8'd0, 16'd0, 32'd0, $urandom, {$urandom, $urandom});
    // Unknown opcodes at both ends of the undefined range.
    send_request(OpcodeCount, 8'd0, 16'd1, 32'd1, $urandom, {$urandom, $urandom});
    send_request(OpcodeMax, 8'd0, 16'd2, 32'd4, $urandom, {$urandom, $urandom});
    // Key plus extras beyond the body wins over every other check.
    send_request(OP_SET, 8'hff, 16'hffff, 32'd2, $urandom, {$urandom, $urandom});
    send_request(OpcodeMax, 8'hff, 16'hffff, 32'd0, $urandom, {$urandom, $urandom});
    // Lookup with an empty key, and lookup with extras.
    send_request(OP_GETQ, 8'd0, 16'd0, 32'd0, $urandom, {$urandom, $urandom});
    send_request(OP_GET, 8'd4, 16'd2, 32'd6, $urandom, {$urandom, $urandom});

    // Random requests, with two long receiver hold-offs along the way.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      if (requests_sent == 30 || requests_sent == 40) hold_req = 1'b1;
      send_random_request();
    end

    // A bad first byte locks the block; everything after it, even a new magic
    // byte, must be swallowed without a record.
    put_byte(8'($urandom_range(0, 127)));
    put_byte(RequestMagic);
    repeat (30) put_byte(8'($urandom));
    req_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d requests in %0d stream bytes: every command kind, length errors,",
             requests_sent, bytes_sent);
    $display("unknown opcodes, bad-magic lockout; %0d descriptors, %0d body bytes matched.",
             desc_count, body_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/kvbrd_pkg.sv
hdl/kvbrd_in_if.sv
hdl/kvbrd_out_if.sv
hdl/kvbrd_hdr_collect.sv
hdl/kvbrd_classify.sv
hdl/kv_binary_request_deframer.sv
sim/kvbrd_tb_pkg.sv
sim/kvbrd_checker.sv
sim/kv_binary_request_deframer_tb.sv
